>>> rtl/core/rbc_pkg.sv
// ----------------------------------------------------------------------------
// rbc_pkg: shared types and constants of the buffer cache tag store
// Slot count, status codes, request and result records, back-end states.
// ----------------------------------------------------------------------------
`default_nettype none
package rbc_pkg;

  localparam int SLOTS   = 64;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int CNT_W   = SLOT_W + 1;
  localparam int REFS_W  = 16;
  localparam int STAMP_W = 32;
  localparam int QDEPTH  = 2;

  localparam logic [2:0] ST_HIT        = 3'd0;
  localparam logic [2:0] ST_MISS       = 3'd1;
  localparam logic [2:0] ST_ZERO       = 3'd2;
  localparam logic [2:0] ST_XLATE_FAIL = 3'd3;
  localparam logic [2:0] ST_EXHAUSTED  = 3'd4;
  localparam logic [2:0] ST_PUT_DONE   = 3'd5;
  localparam logic [2:0] ST_PUT_ERROR  = 3'd6;

  // One classified request waiting for the back end.
  typedef struct packed {
    logic              is_put;
    logic [31:0]       file_inode;
    logic [31:0]       block_index;
    logic [31:0]       device_block;
    logic              address_ok;
    logic [SLOT_W-1:0] release_slot;
  } req_t;

  // One finished result.
  typedef struct packed {
    logic [2:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       fetch_block;
    logic              evicted;
    logic [REFS_W-1:0] ref_count;
  } res_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SCAN,
    B_DECIDE,
    B_PUT,
    B_OUT
  } back_state_t;

endpackage
`default_nettype wire

>>> rtl/core/refcounted_block_buffer_cache_unit.sv
// ----------------------------------------------------------------------------
// refcounted_block_buffer_cache_unit: buffer cache tag store, top level
// Channel   Dir  Beat
// s_axis    in   tuser: kind; tdata: file_inode, block_index, device_block,
//                address_ok, release_slot (from bit 0 up)
// m_axis    out  tuser: status; tdata: slot, fetch_block, evicted, ref_count
// A get scans every slot in use, one a cycle from the tag memory read port,
// then decides in B_DECIDE and presents its result beat in B_OUT.
// A put reads the released slot's count, updates it in B_PUT and presents
// its result beat in B_OUT, where a low m_tready holds it.
// Reset is synchronous; no clearing pass.
// A two-beat queue keeps s_tready high while a result waits on m_tready, until it fills.
// ----------------------------------------------------------------------------
`default_nettype none
module refcounted_block_buffer_cache_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // tdata: file_inode[31:0], block_index[63:32], device_block[95:64],
  //        address_ok[96], release_slot[102:97], zero[103]
  input  wire logic [103:0] s_tdata,
  // tuser: kind[0]
  input  wire logic         s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // tdata: slot[5:0], fetch_block[37:6], evicted[38], ref_count[54:39],
  //        zero[55]
  output logic [55:0]       m_tdata,
  // tuser: status[2:0]
  output logic [2:0]        m_tuser
);
  import rbc_pkg::*;

  logic q_valid;
  logic q_ready;
  req_t q_data;
  res_t res;

  rbc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_kind  (s_tuser),
    .in_inode (s_tdata[31:0]),
    .in_index (s_tdata[63:32]),
    .in_dev   (s_tdata[95:64]),
    .in_ok    (s_tdata[96]),
    .in_rel   (s_tdata[102:97]),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data)
  );

  rbc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res)
  );

  // Pack the result beat.
  assign m_tuser = res.status;
  assign m_tdata = {1'b0, res.ref_count, res.evicted, res.fetch_block, res.slot};

  // A miss always grants a fresh single reference.
  a_miss_one: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_MISS) |-> (m_tdata[54:39] == 16'd1))
    else $error("miss without a single reference");

  // Non-allocating get outcomes report no slot and no count.
  a_noalloc_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == ST_ZERO || m_tuser == ST_XLATE_FAIL ||
                  m_tuser == ST_EXHAUSTED)) |-> (m_tdata[54:0] == 55'd0))
    else $error("non-allocating result carries data");

  // A hit always leaves a held slot.
  a_hit_held: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_HIT) |-> (m_tdata[54:39] != 16'd0))
    else $error("hit with zero count");

endmodule
`default_nettype wire

>>> rtl/core/rbc_front.sv
// ----------------------------------------------------------------------------
// rbc_front: request intake
// Accepts input beats, classifies them as get or put and holds them in a
// short queue in front of the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module rbc_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic         in_kind,
  input  wire logic [31:0]  in_inode,
  input  wire logic [31:0]  in_index,
  input  wire logic [31:0]  in_dev,
  input  wire logic         in_ok,
  input  wire logic [rbc_pkg::SLOT_W-1:0] in_rel,
  output logic              q_valid,
  input  wire logic         q_ready,
  output rbc_pkg::req_t     q_data
);
  import rbc_pkg::*;

  localparam int QP_W = $clog2(QDEPTH);

  req_t              entry [QDEPTH];
  logic [QP_W-1:0]   wp;
  logic [QP_W-1:0]   rp;
  logic [QP_W:0]     count;
  logic              push;
  logic              pop;
  req_t              req_in;

  // Classify the incoming beat.
  always_comb begin
    req_in.is_put       = in_kind;
    req_in.file_inode   = in_inode;
    req_in.block_index  = in_index;
    req_in.device_block = in_dev;
    req_in.address_ok   = in_ok;
    req_in.release_slot = in_rel;
  end

  assign in_ready = (count != (QP_W+1)'(QDEPTH)) ? 1'b1 : 1'b0;
  assign q_valid  = (count != '0);
  assign q_data   = entry[rp];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wp] <= req_in;
    end
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= wp + QP_W'(1);
      end
      if (pop) begin
        rp <= rp + QP_W'(1);
      end
      count <= count + (QP_W+1)'(push) - (QP_W+1)'(pop);
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/rbc_back.sv
// ----------------------------------------------------------------------------
// rbc_back: lookup and allocation engine
// Scans the tag store one slot a cycle on a get, then grants a hit,
// allocates a never-used or oldest released slot or fails; puts update counts.
// ----------------------------------------------------------------------------
`default_nettype none
module rbc_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  output logic               q_ready,
  input  wire rbc_pkg::req_t q_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output rbc_pkg::res_t      out_data
);
  import rbc_pkg::*;

  back_state_t        state;
  back_state_t        state_next;
  req_t               req;
  res_t               res;
  res_t               res_next;

  // Tag store memories.
  logic [63:0]        mem_tag   [SLOTS];
  logic [REFS_W-1:0]  mem_refs  [SLOTS];
  logic [STAMP_W-1:0] mem_stamp [SLOTS];
  logic [SLOT_W-1:0]  rd_addr;
  logic [63:0]        rd_tag;
  logic [REFS_W-1:0]  rd_refs;
  logic [STAMP_W-1:0] rd_stamp;

  // Scan and allocation state.
  logic [CNT_W-1:0]   cnt;
  logic               pvalid;
  logic [SLOT_W-1:0]  paddr;
  logic [CNT_W-1:0]   nun;
  logic               found;
  logic [SLOT_W-1:0]  faddr;
  logic [REFS_W-1:0]  frefs;
  logic               have_old;
  logic [SLOT_W-1:0]  oaddr;
  logic [STAMP_W-1:0] ostamp;
  logic [STAMP_W-1:0] stamp_ctr;

  // Write controls.
  logic               we_tag;
  logic               we_refs;
  logic               we_stamp;
  logic [SLOT_W-1:0]  waddr;
  logic [REFS_W-1:0]  refs_wd;
  logic               nun_inc;
  logic               ctr_inc;
  logic               scan_more;
  logic               put_valid;
  logic [REFS_W-1:0]  refs_dec;

  assign scan_more = (cnt < nun);
  assign put_valid = ({1'b0, req.release_slot} < nun);
  assign refs_dec  = rd_refs - REFS_W'(1);
  assign out_valid = (state == B_OUT);
  assign out_data  = res;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          state_next = q_data.is_put ? B_PUT : B_SCAN;
        end
      end
      B_SCAN: begin
        if (!scan_more && !pvalid) begin
          state_next = B_DECIDE;
        end
      end
      B_DECIDE: state_next = B_OUT;
      B_PUT:    state_next = B_OUT;
      B_OUT: begin
        if (out_ready) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // Outputs: read address, writes and the result.
  always_comb begin
    q_ready  = 1'b0;
    rd_addr  = cnt[SLOT_W-1:0];
    we_tag   = 1'b0;
    we_refs  = 1'b0;
    we_stamp = 1'b0;
    waddr    = faddr;
    refs_wd  = '0;
    nun_inc  = 1'b0;
    ctr_inc  = 1'b0;
    res_next = res;
    case (state)
      B_IDLE: begin
        q_ready = 1'b1;
        rd_addr = q_data.release_slot;
      end
      B_DECIDE: begin
        res_next = '0;
        if (found) begin
          // Hit: raise the count, saturating at its top.
          we_refs            = 1'b1;
          waddr              = faddr;
          refs_wd            = (frefs == '1) ? frefs : frefs + REFS_W'(1);
          res_next.status    = ST_HIT;
          res_next.slot      = faddr;
          res_next.ref_count = refs_wd;
        end else if (!req.address_ok) begin
          res_next.status = ST_XLATE_FAIL;
        end else if (req.device_block == '0) begin
          res_next.status = ST_ZERO;
        end else if (nun < CNT_W'(SLOTS) || have_old) begin
          // Miss: a never-used slot first, else the oldest released one.
          we_tag               = 1'b1;
          we_refs              = 1'b1;
          refs_wd              = REFS_W'(1);
          nun_inc              = (nun < CNT_W'(SLOTS));
          waddr                = nun_inc ? nun[SLOT_W-1:0] : oaddr;
          res_next.status      = ST_MISS;
          res_next.slot        = waddr;
          res_next.fetch_block = req.device_block;
          res_next.evicted     = !nun_inc;
          res_next.ref_count   = REFS_W'(1);
        end else begin
          res_next.status = ST_EXHAUSTED;
        end
      end
      B_PUT: begin
        res_next      = '0;
        res_next.slot = req.release_slot;
        waddr         = req.release_slot;
        if (!put_valid) begin
          res_next.status = ST_PUT_ERROR;
        end else if (rd_refs == '0) begin
          res_next.status = ST_PUT_ERROR;
        end else begin
          // Release one reference; a count reaching zero takes a stamp.
          we_refs            = 1'b1;
          refs_wd            = refs_dec;
          we_stamp           = (refs_dec == '0);
          ctr_inc            = we_stamp;
          res_next.status    = ST_PUT_DONE;
          res_next.ref_count = refs_dec;
        end
      end
      default: begin
      end
    endcase
  end

  // Memories with registered reads.
  always_ff @(posedge clk) begin
    rd_tag   <= mem_tag[rd_addr];
    rd_refs  <= mem_refs[rd_addr];
    rd_stamp <= mem_stamp[rd_addr];
    if (we_tag) begin
      mem_tag[waddr] <= {req.file_inode, req.block_index};
    end
    if (we_refs) begin
      mem_refs[waddr] <= refs_wd;
    end
    if (we_stamp) begin
      mem_stamp[waddr] <= stamp_ctr;
    end
  end

  // Request and result holding registers.
  always_ff @(posedge clk) begin
    if (state == B_IDLE && q_valid) begin
      req <= q_data;
    end
    res <= res_next;
  end

  // Scan bookkeeping: match search and oldest released slot.
  always_ff @(posedge clk) begin
    if (state == B_IDLE) begin
      cnt      <= '0;
      pvalid   <= 1'b0;
      found    <= 1'b0;
      have_old <= 1'b0;
    end else if (state == B_SCAN) begin
      pvalid <= scan_more;
      paddr  <= cnt[SLOT_W-1:0];
      if (scan_more) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (pvalid) begin
        if (rd_tag == {req.file_inode, req.block_index}) begin
          found <= 1'b1;
          faddr <= paddr;
          frefs <= rd_refs;
        end
        if (rd_refs == '0 && (!have_old || rd_stamp < ostamp)) begin
          have_old <= 1'b1;
          oaddr    <= paddr;
          ostamp   <= rd_stamp;
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      nun       <= '0;
      stamp_ctr <= '0;
    end else begin
      state <= state_next;
      if (nun_inc) begin
        nun <= nun + CNT_W'(1);
      end
      if (ctr_inc) begin
        stamp_ctr <= stamp_ctr + STAMP_W'(1);
      end
    end
  end

endmodule
`default_nettype wire
